// ===== rtl/lfu_pkg.sv =====
// Shared constants and types for the LFU cache table.
package lfu_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int FREQ_W      = 32;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};
    localparam logic [FREQ_W-1:0] FREQ_MAX   = {FREQ_W{1'b1}};
    localparam logic [FREQ_W-1:0] FREQ_FIRST = FREQ_W'(1);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One table row as it sits in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [FREQ_W-1:0] freq;
    } entry_word_t;

    localparam int ENTRY_W = $bits(entry_word_t);

endpackage

// ===== rtl/lfu_cache_table_top.sv =====
// Top level of the LFU cache table: sequencer, scan datapath and rank lanes.
//
// Usage: a request item (op, key, value) enters on the input channel when
// in_valid and in_ready are both high; op selects a get or a put. Exactly one
// result item (hit, read_value, evicted, evicted_key) leaves on the output
// channel for every request, in order, when out_valid and out_ready are high.
// The capacity register is to be written through cfg_wr_en / cfg_wr_data only
// while the block is idle (unchecked by the block) and takes effect on the next request.
//
// Scan: every request walks the whole table once through the single read
// port of the entry memory, one entry per cycle, comparing keys and tracking
// the victim with one shared compare unit. The update step then writes the
// result to the output register, and the next request is accepted only once
// the block is back in idle, so one request is finished before the next.
//
// Reset clears all valid bits, the occupancy count and the output valid flag,
// and loads the capacity with its reset value of 16. A finished result waits
// in the output register; if the receiver stalls and the previous result is
// still held, the update step waits and in_ready stays low until it drains.
module lfu_cache_table_top #(
    parameter int ENTRIES = lfu_pkg::DEF_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic signed [lfu_pkg::KEY_W-1:0]  key,
    input  logic signed [lfu_pkg::DATA_W-1:0] value,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic signed [lfu_pkg::DATA_W-1:0] read_value,
    output logic                         evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key,
    // Capacity register
    input  logic                         cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0]    cfg_wr_data
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Request latched at accept.
    logic                        req_op_reg;
    logic [lfu_pkg::KEY_W-1:0]   req_key_reg;
    logic [lfu_pkg::DATA_W-1:0]  req_value_reg;

    // Scan pointer and the entry whose memory data is arriving this cycle.
    logic [AW-1:0]               scan_idx_reg;
    logic                        p_vld_reg;
    logic [AW-1:0]               p_idx_reg;
    logic [AW-1:0]               rank_rd_reg;

    // Scan results.
    logic                        hit_reg;
    logic [AW-1:0]               s_idx_reg;
    logic [AW-1:0]               s_rank_reg;
    logic [lfu_pkg::DATA_W-1:0]  s_data_reg;
    logic [lfu_pkg::FREQ_W-1:0]  s_freq_reg;
    logic                        vic_found_reg;
    logic [AW-1:0]               vic_idx_reg;
    logic [lfu_pkg::FREQ_W-1:0]  vic_freq_reg;
    logic [AW-1:0]               vic_rank_reg;
    logic [lfu_pkg::KEY_W-1:0]   vic_key_reg;
    logic                        inv_found_reg;
    logic [AW-1:0]               inv_idx_reg;

    // Table state kept in flip-flops.
    logic [ENTRIES-1:0]          valid_reg, valid_next;
    logic [AW-1:0]               rank_reg [ENTRIES];
    logic [AW-1:0]               rank_next [ENTRIES];
    logic [OCC_W-1:0]            occ_reg, occ_next;
    logic [lfu_pkg::CAP_W-1:0]   cap_reg;

    // Output register.
    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [lfu_pkg::DATA_W-1:0]  out_rd_reg;
    logic                        out_ev_reg;
    logic [lfu_pkg::KEY_W-1:0]   out_evk_reg;

    // Entry memory.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    lfu_pkg::entry_word_t        ram_wdata;
    lfu_pkg::entry_word_t        ram_rdata;

    logic accept;
    logic scan_last;
    logic e_valid;
    logic key_match;
    logic better;
    logic upd_go;

    logic [CMP_W-1:0]            cap_eff;
    logic                        cap_zero;
    logic                        is_put;
    logic                        do_touch;
    logic                        put_miss;
    logic                        do_evict;
    logic                        do_insert;
    logic [AW-1:0]               ins_idx;
    logic [lfu_pkg::FREQ_W-1:0]  freq_inc;

    lfu_ram #(
        .WIDTH (lfu_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign scan_last = (scan_idx_reg == AW'(ENTRIES - 1));

    // Shared compare unit: one entry per cycle.
    assign e_valid   = p_vld_reg && valid_reg[p_idx_reg];
    assign key_match = e_valid && (ram_rdata.key == req_key_reg);
    assign better    = e_valid && (!vic_found_reg
                                   || (ram_rdata.freq < vic_freq_reg)
                                   || ((ram_rdata.freq == vic_freq_reg)
                                       && (rank_rd_reg > vic_rank_reg)));

    // Update decision, taken once the scan has finished.
    assign cap_eff   = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                            : CMP_W'(cap_reg);
    assign cap_zero  = (cap_eff == '0);
    assign is_put    = (req_op_reg == lfu_pkg::OP_PUT);
    assign do_touch  = hit_reg && (!is_put || !cap_zero);
    assign put_miss  = is_put && !cap_zero && !hit_reg;
    assign do_evict  = put_miss && (CMP_W'(occ_reg) >= cap_eff) && vic_found_reg;
    assign do_insert = put_miss && (do_evict || inv_found_reg);
    assign ins_idx   = (do_evict && (!inv_found_reg || (vic_idx_reg < inv_idx_reg)))
                       ? vic_idx_reg : inv_idx_reg;
    assign freq_inc  = (s_freq_reg == lfu_pkg::FREQ_MAX)
                       ? s_freq_reg : s_freq_reg + lfu_pkg::FREQ_W'(1);
    assign upd_go    = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    // A touch rewrites the hit row; an insert writes a fresh row.
    always_comb
    begin
        ram_we    = upd_go && (do_touch || do_insert);
        ram_waddr = do_touch ? s_idx_reg : ins_idx;
        ram_wdata.key = req_key_reg;
        if (do_touch)
        begin
            ram_wdata.data = is_put ? req_value_reg : s_data_reg;
            ram_wdata.freq = freq_inc;
        end
        else
        begin
            ram_wdata.data = req_value_reg;
            ram_wdata.freq = lfu_pkg::FREQ_FIRST;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (upd_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Recency lanes, valid bits and occupancy, all updated in one step.
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_touch)
            begin
                if (int'(s_idx_reg) == i)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i])
                begin
                    if (rank_reg[i] < s_rank_reg)
                    begin
                        rank_next[i] = rank_reg[i] + AW'(1);
                    end
                end
            end
            else if (do_insert)
            begin
                if (int'(ins_idx) == i)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && !(do_evict && (int'(vic_idx_reg) == i)))
                begin
                    if (!(do_evict && (rank_reg[i] > vic_rank_reg)))
                    begin
                        rank_next[i] = rank_reg[i] + AW'(1);
                    end
                end
            end
        end
        if (do_evict)
        begin
            valid_next[vic_idx_reg] = 1'b0;
            occ_next = occ_next - OCC_W'(1);
        end
        if (do_insert)
        begin
            valid_next[ins_idx] = 1'b1;
            occ_next = occ_next + OCC_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            p_vld_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            vic_found_reg <= 1'b0;
            inv_found_reg <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= lfu_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_vld_reg <= (state_reg == S_SCAN);

            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end

            if (accept)
            begin
                scan_idx_reg  <= '0;
                hit_reg       <= 1'b0;
                vic_found_reg <= 1'b0;
                inv_found_reg <= 1'b0;
            end
            else
            begin
                if ((state_reg == S_SCAN) && !scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + AW'(1);
                end
                if (key_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (better)
                begin
                    vic_found_reg <= 1'b1;
                end
                if (p_vld_reg && !valid_reg[p_idx_reg])
                begin
                    inv_found_reg <= 1'b1;
                end
            end

            if (upd_go)
            begin
                valid_reg     <= valid_next;
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        p_idx_reg   <= scan_idx_reg;
        rank_rd_reg <= rank_reg[scan_idx_reg];

        if (accept)
        begin
            req_op_reg    <= op;
            req_key_reg   <= key;
            req_value_reg <= value;
        end

        if (key_match)
        begin
            s_idx_reg  <= p_idx_reg;
            s_rank_reg <= rank_rd_reg;
            s_data_reg <= ram_rdata.data;
            s_freq_reg <= ram_rdata.freq;
        end
        if (better)
        begin
            vic_idx_reg  <= p_idx_reg;
            vic_freq_reg <= ram_rdata.freq;
            vic_rank_reg <= rank_rd_reg;
            vic_key_reg  <= ram_rdata.key;
        end
        if (p_vld_reg && !valid_reg[p_idx_reg] && !inv_found_reg)
        begin
            inv_idx_reg <= p_idx_reg;
        end

        if (upd_go)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            out_hit_reg <= hit_reg;
            if (is_put)
            begin
                out_rd_reg <= '0;
            end
            else
            begin
                out_rd_reg <= hit_reg ? s_data_reg : lfu_pkg::MISS_VALUE;
            end
            out_ev_reg  <= do_evict;
            out_evk_reg <= do_evict ? vic_key_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign read_value  = out_rd_reg;
    assign evicted     = out_ev_reg;
    assign evicted_key = out_evk_reg;

    // The occupancy count always equals the number of valid entries.
    a_occ_matches_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count differs from valid bits");

    // An eviction only comes from a put miss, which reports no hit and zero data.
    a_evict_shape: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> (!hit && (read_value == '0)))
        else $error("eviction reported on a hit or with nonzero data");

    // An accepted request always starts a table scan from the first entry.
    a_accept_starts_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg == S_SCAN) && (scan_idx_reg == '0)))
        else $error("accepted request did not start a scan");

    // A new result is only loaded once the previous one has been taken.
    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(read_value) && $stable(evicted_key)))
        else $error("held result was overwritten");

endmodule

// ===== rtl/lfu_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
